FILE: rtl/core/fpa_pkg.sv
// fpa_pkg: types, register indexes, profile codes and helpers shared by the
// fracture point aperture block. No dependencies.
package fpa_pkg;

   localparam int CsrIndexWidth = 3;
   localparam int QueueDepth    = 4;
   localparam int QueuePtrWidth = 2;

   localparam logic [CsrIndexWidth-1:0] CSR_CENTER_X     = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_CENTER_Y     = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_COS_ANGLE    = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_SIN_ANGLE    = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_FRAC_LENGTH  = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CSR_INV_LENGTH   = 3'd5;
   localparam logic [CsrIndexWidth-1:0] CSR_MAX_APERTURE = 3'd6;
   localparam logic [CsrIndexWidth-1:0] CSR_PROFILE_MODE = 3'd7;

   localparam logic [2:0] MODE_CONSTANT  = 3'd0;
   localparam logic [2:0] MODE_LINEAR    = 3'd1;
   localparam logic [2:0] MODE_QUADRATIC = 3'd2;
   localparam logic [2:0] MODE_ELLIPTIC  = 3'd3;
   localparam logic [2:0] MODE_ONESIDED  = 3'd4;

   localparam logic [24:0] ONE_Q24 = 25'h100_0000;

   typedef struct packed {
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic signed [15:0] cos_angle;
      logic signed [15:0] sin_angle;
      logic [31:0]        frac_length;
      logic [31:0]        inv_length;
      logic [31:0]        max_aperture;
      logic [2:0]         profile_mode;
   } cfg_type;

   // classified point passed from front to back
   typedef struct packed {
      logic        ok;      // within length and a valid mode
      logic        lx_neg;
      logic [31:0] ax2;     // 2|lx|, only meaningful when ok
      logic [36:0] ay2;     // 2|ly|
   } entry_type;

   // eight steps of long division by three: returns {remainder, quotient byte}
   function automatic logic [9:0] div3_step8(input logic [1:0] rem_i,
                                             input logic [7:0] bits_i);
      logic [1:0] rem;
      logic [2:0] t;
      logic [7:0] q;
      rem = rem_i;
      q   = '0;
      for (int i = 7; i >= 0; i--) begin
         t = {rem, bits_i[i]};
         if (t >= 3'd3) begin
            q[i] = 1'b1;
            rem  = 2'(t - 3'd3);
         end else begin
            rem  = t[1:0];
         end
      end
      return {rem, q};
   endfunction

endpackage

FILE: rtl/core/fracture_point_aperture_top.sv
// fracture_point_aperture_top: configuration registers, front, queue and back
// of the fracture point aperture block. Depends on fpa_pkg and all fpa_ modules.
//
// Takes one point per clock while req_stall is low and gives one result beat
// per point, in order. A point passes three front stages, then the four-entry
// queue, then the back pipeline of 4 + (SQRT_BITS/2 + 1) + 3 + 8 stages. The
// length of the back pipeline is set by the square-root unit (one result bit
// per stage) and the divide by twelve (one dividend byte per stage). A stalled
// result freezes the back pipeline; the front keeps accepting until the queue
// fills. Write the registers only while no point is in flight.
module fracture_point_aperture_top import fpa_pkg::*; #(
   parameter int COORD_FRAC_BITS = 16,
   parameter int SQRT_BITS       = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_en,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [31:0]              csr_wdata,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [31:0]       req_point_x,
   input  logic signed [31:0]       req_point_y,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_inside_res,
   output logic [31:0]              rsp_aperture,
   output logic [60:0]              rsp_permeability
);

   cfg_type   cfg_ff;
   logic      front_valid, front_advance;
   entry_type front_entry, q_head;
   logic      q_empty, q_full, q_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.center_x     <= '0;
         cfg_ff.center_y     <= '0;
         cfg_ff.cos_angle    <= 16'sd16384;
         cfg_ff.sin_angle    <= '0;
         cfg_ff.frac_length  <= 32'd65536;
         cfg_ff.inv_length   <= 32'd16777216;
         cfg_ff.max_aperture <= '0;
         cfg_ff.profile_mode <= MODE_CONSTANT;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_CENTER_X:     cfg_ff.center_x     <= csr_wdata;
            CSR_CENTER_Y:     cfg_ff.center_y     <= csr_wdata;
            CSR_COS_ANGLE:    cfg_ff.cos_angle    <= csr_wdata[15:0];
            CSR_SIN_ANGLE:    cfg_ff.sin_angle    <= csr_wdata[15:0];
            CSR_FRAC_LENGTH:  cfg_ff.frac_length  <= csr_wdata;
            CSR_INV_LENGTH:   cfg_ff.inv_length   <= csr_wdata;
            CSR_MAX_APERTURE: cfg_ff.max_aperture <= csr_wdata;
            CSR_PROFILE_MODE: cfg_ff.profile_mode <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   // the front moves unless its last stage is held by a full queue
   assign front_advance = !(front_valid && q_full);
   assign req_stall     = !front_advance;

   fpa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_valid),
      .in_x      (req_point_x),
      .in_y      (req_point_y),
      .advance   (front_advance),
      .out_valid (front_valid),
      .out_entry (front_entry)
   );

   fpa_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (front_valid),
      .push_entry (front_entry),
      .pop        (q_pop),
      .empty      (q_empty),
      .full       (q_full),
      .head       (q_head)
   );

   fpa_back #(
      .COORD_FRAC_BITS (COORD_FRAC_BITS),
      .SQRT_BITS       (SQRT_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .q_empty          (q_empty),
      .q_head           (q_head),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_inside_res   (rsp_inside_res),
      .rsp_aperture     (rsp_aperture),
      .rsp_permeability (rsp_permeability)
   );

endmodule

FILE: rtl/core/fpa_front.sv
// fpa_front: translate and rotate a global point into the fracture frame and
// classify it against the length and mode. Depends on fpa_pkg.
module fpa_front import fpa_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               in_valid,
   input  logic signed [31:0] in_x,
   input  logic signed [31:0] in_y,
   input  logic               advance,
   output logic               out_valid,
   output entry_type          out_entry
);

   logic               v1_ff, v2_ff, v3_ff;
   logic signed [32:0] dx_ff, dy_ff;
   logic signed [48:0] cdx_ff, sdy_ff, cdy_ff, sdx_ff;
   entry_type          ent_ff;

   logic signed [48:0] cos_e, sin_e, dx_e, dy_e;
   logic signed [49:0] sx, sy;
   logic signed [35:0] lx, ly;
   logic [35:0]        mag_x, mag_y;
   logic [36:0]        ax2, ay2;
   entry_type          ent_in;

   always_comb begin
      cos_e = 49'(cfg.cos_angle);
      sin_e = 49'(cfg.sin_angle);
      dx_e  = 49'(dx_ff);
      dy_e  = 49'(dy_ff);
      sx    = 50'(cdx_ff) + 50'(sdy_ff);
      sy    = 50'(cdy_ff) - 50'(sdx_ff);
      // floor shift by 14
      lx    = sx[49:14];
      ly    = sy[49:14];
      mag_x = lx[35] ? 36'(-lx) : 36'(lx);
      mag_y = ly[35] ? 36'(-ly) : 36'(ly);
      ax2   = {mag_x, 1'b0};
      ay2   = {mag_y, 1'b0};
      ent_in.ok     = (ax2 <= {5'b0, cfg.frac_length}) && (cfg.profile_mode <= MODE_ONESIDED);
      ent_in.lx_neg = lx[35];
      ent_in.ax2    = ax2[31:0];
      ent_in.ay2    = ay2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dx_ff  <= 33'(in_x) - 33'(cfg.center_x);
         dy_ff  <= 33'(in_y) - 33'(cfg.center_y);
         cdx_ff <= cos_e * dx_e;
         sdy_ff <= sin_e * dy_e;
         cdy_ff <= cos_e * dy_e;
         sdx_ff <= sin_e * dx_e;
         ent_ff <= ent_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_entry = ent_ff;

endmodule

FILE: rtl/core/fpa_queue.sv
// fpa_queue: short first-in first-out queue between front and back.
// Depends on fpa_pkg.
module fpa_queue import fpa_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output logic      empty,
   output logic      full,
   output entry_type head
);

   entry_type                store_ff [QueueDepth];
   logic [QueuePtrWidth-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QueuePtrWidth:0]   count_ff;
   logic                     do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == (QueuePtrWidth+1)'(QueueDepth));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = store_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (do_push && !do_pop)      count_ff <= count_ff + 1'b1;
         else if (do_pop && !do_push) count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) store_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

FILE: rtl/core/fpa_sqrt.sv
// fpa_sqrt: pipelined floor integer square root, one result bit per stage.
// No dependencies.
module fpa_sqrt #(
   parameter int RootFrac = 16
) (
   input  logic                  clock,
   input  logic                  enable,
   input  logic [2*RootFrac+1:0] radicand,
   output logic [RootFrac:0]     root
);

   localparam int Stages = RootFrac + 1;
   localparam int VW     = 2 * RootFrac + 2;
   localparam int RW     = RootFrac + 2;

   logic [VW-1:0]       v_ff   [Stages];
   logic [RW-1:0]       rem_ff [Stages];
   logic [RootFrac:0]   res_ff [Stages];

   genvar s;
   generate
      for (s = 0; s < Stages; s++) begin : g_stage
         logic [VW-1:0]     v_prev;
         logic [RW-1:0]     rem_prev;
         logic [RootFrac:0] res_prev;
         logic [RW+1:0]     rs, tr;
         if (s == 0) begin : g_first
            assign v_prev   = radicand;
            assign rem_prev = '0;
            assign res_prev = '0;
         end else begin : g_next
            assign v_prev   = v_ff[s-1];
            assign rem_prev = rem_ff[s-1];
            assign res_prev = res_ff[s-1];
         end
         assign rs = {rem_prev, v_prev[VW-1:VW-2]};
         assign tr = (RW+2)'({res_prev, 2'b01});
         always_ff @(posedge clock) begin
            if (enable) begin
               v_ff[s] <= {v_prev[VW-3:0], 2'b00};
               if (rs >= tr) begin
                  rem_ff[s] <= RW'(rs - tr);
                  res_ff[s] <= {res_prev[RootFrac-1:0], 1'b1};
               end else begin
                  rem_ff[s] <= RW'(rs);
                  res_ff[s] <= {res_prev[RootFrac-1:0], 1'b0};
               end
            end
         end
      end
   endgenerate

   assign root = res_ff[Stages-1];

endmodule

FILE: rtl/core/fpa_back.sv
// fpa_back: evaluates the aperture profile, the inside test and the
// permeability for each queued point. Depends on fpa_pkg and fpa_sqrt.
module fpa_back import fpa_pkg::*; #(
   parameter int COORD_FRAC_BITS = 16,
   parameter int SQRT_BITS       = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        q_empty,
   input  entry_type   q_head,
   output logic        q_pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_inside_res,
   output logic [31:0] rsp_aperture,
   output logic [60:0] rsp_permeability
);

   localparam int RF       = SQRT_BITS / 2;
   localparam int VW       = 2 * RF + 2;
   localparam int SqStages = RF + 1;
   localparam int DivSteps = 8;

   typedef struct packed {
      logic        ok;
      logic        is_ell;
      logic [36:0] ay2;
      logic [31:0] a_pre;
   } side_type;

   logic advance;

   // profile stages
   logic        v1_ff, v2_ff, v3_ff, v4_ff;
   entry_type   e1_ff, e2_ff, e3_ff;
   logic [63:0] rfull_ff;
   logic [24:0] r_ff, q_ff;
   logic [31:0] p_ff;
   side_type    s4_ff;
   logic [VW-1:0] v_sq_ff;

   logic [63:0] rsh;
   logic [24:0] fac;
   logic [25:0] one_plus;
   logic [24:0] one_minus, one_minus_q;
   logic [56:0] prod_lin, prod_q;
   logic [VW-1:0] v_sq_in;
   side_type    s4_in;

   // sqrt sideband, end stages, divider
   side_type           sb_ff [SqStages];
   logic               sv_ff [SqStages];
   logic [RF:0]        root;
   logic               ve1_ff, ve2_ff, ve3_ff;
   logic               ok_e1_ff;
   logic [36:0]        ay2_e1_ff;
   logic [31:0]        a_e1_ff, ap_e2_ff, ap_e3_ff;
   logic               ins_e2_ff, ins_e3_ff;
   logic [63:0]        word_e3_ff;
   logic [RF+32:0]     prod_ell;
   logic [31:0]        a_e1_in;
   logic               ins_in;

   logic               dv_ff  [DivSteps];
   logic [63:0]        dw_ff  [DivSteps];
   logic [1:0]         drem_ff[DivSteps];
   logic               dins_ff[DivSteps];
   logic [31:0]        dap_ff [DivSteps];

   assign advance = !dv_ff[DivSteps-1] || !rsp_stall;
   assign q_pop   = advance && !q_empty;

   always_comb begin
      rsh       = rfull_ff >> COORD_FRAC_BITS;
      one_minus = ONE_Q24 - r_ff;
      one_plus  = 26'(ONE_Q24) + 26'(r_ff);
      // r_ff and e2_ff hold the same point here
      unique case (cfg.profile_mode)
         MODE_ONESIDED: fac = e2_ff.lx_neg ? {1'b0, one_minus[24:1]} : one_plus[25:1];
         default:       fac = one_minus;
      endcase
      prod_lin    = 57'(cfg.max_aperture) * 57'(fac);
      one_minus_q = ONE_Q24 - q_ff;
      prod_q      = 57'(cfg.max_aperture) * 57'(one_minus_q);
      s4_in.ok     = e3_ff.ok;
      s4_in.ay2    = e3_ff.ay2;
      s4_in.is_ell = (cfg.profile_mode == MODE_ELLIPTIC);
      unique case (cfg.profile_mode) inside
         MODE_CONSTANT:               s4_in.a_pre = cfg.max_aperture;
         MODE_LINEAR, MODE_ONESIDED:  s4_in.a_pre = p_ff;
         MODE_QUADRATIC:              s4_in.a_pre = prod_q[55:24];
         default:                     s4_in.a_pre = '0;
      endcase
   end

   // rescale 1-q from Q.24 to Q.(2*RF)
   generate
      if (2 * RF >= 24) begin : g_shl
         assign v_sq_in = VW'(one_minus_q) << (2 * RF - 24);
      end else begin : g_shr
         assign v_sq_in = VW'(one_minus_q >> (24 - 2 * RF));
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= !q_empty;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         e1_ff    <= q_head;
         rfull_ff <= 64'(q_head.ax2) * 64'(cfg.inv_length);
         e2_ff    <= e1_ff;
         // ratio saturates at one
         r_ff     <= (rsh > 64'(ONE_Q24)) ? ONE_Q24 : rsh[24:0];
         e3_ff    <= e2_ff;
         q_ff     <= 25'((50'(r_ff) * 50'(r_ff)) >> 24);
         p_ff     <= prod_lin[55:24];
         s4_ff    <= s4_in;
         v_sq_ff  <= v_sq_in;
      end
   end

   fpa_sqrt #(
      .RootFrac (RF)
   ) u_sqrt (
      .clock    (clock),
      .enable   (advance),
      .radicand (v_sq_ff),
      .root     (root)
   );

   genvar s;
   generate
      for (s = 0; s < SqStages; s++) begin : g_side
         always_ff @(posedge clock) begin
            if (reset) begin
               sv_ff[s] <= 1'b0;
            end else if (advance) begin
               sv_ff[s] <= (s == 0) ? v4_ff : sv_ff[(s == 0) ? 0 : s-1];
            end
         end
         always_ff @(posedge clock) begin
            if (advance) begin
               sb_ff[s] <= (s == 0) ? s4_ff : sb_ff[(s == 0) ? 0 : s-1];
            end
         end
      end
   endgenerate

   always_comb begin
      prod_ell = (RF+33)'(cfg.max_aperture) * (RF+33)'(root);
      a_e1_in  = sb_ff[SqStages-1].is_ell ? prod_ell[RF+31:RF] : sb_ff[SqStages-1].a_pre;
      ins_in   = ok_e1_ff && (ay2_e1_ff <= {5'b0, a_e1_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ve1_ff <= 1'b0;
         ve2_ff <= 1'b0;
         ve3_ff <= 1'b0;
      end else if (advance) begin
         ve1_ff <= sv_ff[SqStages-1];
         ve2_ff <= ve1_ff;
         ve3_ff <= ve2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ok_e1_ff   <= sb_ff[SqStages-1].ok;
         ay2_e1_ff  <= sb_ff[SqStages-1].ay2;
         a_e1_ff    <= a_e1_in;
         ins_e2_ff  <= ins_in;
         ap_e2_ff   <= ins_in ? a_e1_ff : '0;
         ins_e3_ff  <= ins_e2_ff;
         ap_e3_ff   <= ap_e2_ff;
         // square then drop the factor of four, leaving a divide by three
         word_e3_ff <= {2'b00, 62'((64'(ap_e2_ff) * 64'(ap_e2_ff)) >> 2)};
      end
   end

   // divide by three, one byte of the dividend per stage
   generate
      for (s = 0; s < DivSteps; s++) begin : g_div
         logic [63:0] w_prev;
         logic [1:0]  rem_prev;
         logic        ins_prev, v_prev;
         logic [31:0] ap_prev;
         logic [9:0]  step;
         if (s == 0) begin : g_first
            assign w_prev   = word_e3_ff;
            assign rem_prev = '0;
            assign ins_prev = ins_e3_ff;
            assign ap_prev  = ap_e3_ff;
            assign v_prev   = ve3_ff;
         end else begin : g_next
            assign w_prev   = dw_ff[s-1];
            assign rem_prev = drem_ff[s-1];
            assign ins_prev = dins_ff[s-1];
            assign ap_prev  = dap_ff[s-1];
            assign v_prev   = dv_ff[s-1];
         end
         assign step = div3_step8(rem_prev, w_prev[63:56]);
         always_ff @(posedge clock) begin
            if (reset) begin
               dv_ff[s] <= 1'b0;
            end else if (advance) begin
               dv_ff[s] <= v_prev;
            end
         end
         always_ff @(posedge clock) begin
            if (advance) begin
               dw_ff[s]   <= {w_prev[55:0], step[7:0]};
               drem_ff[s] <= step[9:8];
               dins_ff[s] <= ins_prev;
               dap_ff[s]  <= ap_prev;
            end
         end
      end
   endgenerate

   assign rsp_valid        = dv_ff[DivSteps-1];
   assign rsp_inside_res   = dins_ff[DivSteps-1];
   assign rsp_aperture     = dap_ff[DivSteps-1];
   assign rsp_permeability = dw_ff[DivSteps-1][60:0];

endmodule

FILE: tb/fracture_point_aperture_top_tb.sv
// fracture_point_aperture_top_tb: self-checking testbench for the fracture point
// aperture block; depends on fpa_pkg and fracture_point_aperture_top only.
// A scoreboard predicts each point's result and checks beats in order.
`timescale 1ns / 1ps

module fracture_point_aperture_top_tb;
   import fpa_pkg::*;

   typedef struct {
      logic        inside_res;
      logic [31:0] aperture;
      logic [60:0] permeability;
   } aperture_result_type;

   class aperture_scoreboard;
      cfg_type             regs;
      aperture_result_type awaited[$];
      int                  mismatches;

      function void reset_regs();
         regs              = '0;
         regs.cos_angle    = 16'sd16384;
         regs.frac_length  = 32'd65536;
         regs.inv_length   = 32'd16777216;
      endfunction

      function void set_reg(logic [CsrIndexWidth-1:0] idx, logic [31:0] data);
         case (idx)
            CSR_CENTER_X:     regs.center_x     = data;
            CSR_CENTER_Y:     regs.center_y     = data;
            CSR_COS_ANGLE:    regs.cos_angle    = data[15:0];
            CSR_SIN_ANGLE:    regs.sin_angle    = data[15:0];
            CSR_FRAC_LENGTH:  regs.frac_length  = data;
            CSR_INV_LENGTH:   regs.inv_length   = data;
            CSR_MAX_APERTURE: regs.max_aperture = data;
            default:          regs.profile_mode = data[2:0];
         endcase
      endfunction

      function longint unsigned int_sqrt(longint unsigned v);
         longint unsigned res, bitv;
         res  = 0;
         bitv = 64'd1 << 62;
         while (bitv > v) bitv = bitv >> 2;
         while (bitv != 0) begin
            if (v >= res + bitv) begin
               v   = v - (res + bitv);
               res = (res >> 1) + bitv;
            end else begin
               res = res >> 1;
            end
            bitv = bitv >> 2;
         end
         return res;
      endfunction

      function longint unsigned opening_at(longint signed lx, longint unsigned alx);
         longint unsigned r, q, one, amax, f;
         one  = 64'd1 << 24;
         amax = regs.max_aperture;
         r    = ((alx << 1) * longint'(regs.inv_length)) >> 16;
         if (r > one) r = one;
         q = (r * r) >> 24;
         case (regs.profile_mode)
            MODE_CONSTANT:  return amax;
            MODE_LINEAR:    return (amax * (one - r)) >> 24;
            MODE_QUADRATIC: return (amax * (one - q)) >> 24;
            MODE_ELLIPTIC:  return (amax * int_sqrt((one - q) << 8)) >> 16;
            MODE_ONESIDED: begin
               f = (lx >= 0 ? one + r : one - r) >> 1;
               return (amax * f) >> 24;
            end
            default:        return 0;
         endcase
      endfunction

      function void note_point(logic signed [31:0] px, logic signed [31:0] py);
         longint signed       dx, dy, lx, ly, cs, sn;
         longint unsigned     alx, aly, a, ap;
         aperture_result_type res;
         cs  = regs.cos_angle;
         sn  = regs.sin_angle;
         dx  = longint'(px) - longint'(regs.center_x);
         dy  = longint'(py) - longint'(regs.center_y);
         lx  = (cs * dx + sn * dy) >>> 14;
         ly  = (cs * dy - sn * dx) >>> 14;
         alx = lx < 0 ? -lx : lx;
         aly = ly < 0 ? -ly : ly;
         ap  = 0;
         res.inside_res = 1'b0;
         if ((alx << 1) <= longint'(regs.frac_length) && regs.profile_mode <= MODE_ONESIDED)
         begin
            a = opening_at(lx, alx);
            if ((aly << 1) <= a) begin
               res.inside_res = 1'b1;
               ap = a & 64'hFFFF_FFFF;
            end
         end
         res.aperture     = ap[31:0];
         res.permeability = 61'((ap * ap) / 12);
         awaited.push_back(res);
      endfunction

      function void check_beat(logic got_in, logic [31:0] ap, logic [60:0] perm);
         aperture_result_type e;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat at %0t", $realtime);
            return;
         end
         e = awaited.pop_front();
         if (e.inside_res !== got_in || e.aperture !== ap || e.permeability !== perm) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch at %0t: exp inside %0d ap %h perm %h, got %0d %h %h",
                        $realtime, e.inside_res, e.aperture, e.permeability, got_in, ap,
                        perm);
         end
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     csr_write_en;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [31:0]              csr_wdata;
   logic                     req_valid;
   logic                     req_stall;
   logic signed [31:0]       req_point_x;
   logic signed [31:0]       req_point_y;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic                     rsp_inside_res;
   logic [31:0]              rsp_aperture;
   logic [60:0]              rsp_permeability;

   aperture_scoreboard sb;
   bit                 idling;      // draw gaps and stalls when set
   bit                 hold_off;    // receiver does one long stall

   fracture_point_aperture_top i_dut (.*);

   always begin
      clock = 1'b0; #10;
      clock = 1'b1; #10;
   end

   initial begin
      #20ms;
      $display("FAILURE");
      $finish;
   end

   task automatic csr_write(logic [CsrIndexWidth-1:0] idx, logic [31:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      sb.set_reg(idx, data);
   endtask

   task automatic drain();
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic send_point(logic [31:0] px, logic [31:0] py);
      int gap;
      gap = idling ? $urandom_range(0, 16) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_point_x <= px;
      req_point_y <= py;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      sb.note_point(px, py);
   endtask

   // a point placed near the fracture in its local frame, then rotated back
   task automatic send_near();
      longint signed lx, ly, span_x, span_y, cs, sn, gx, gy;
      cs     = sb.regs.cos_angle;
      sn     = sb.regs.sin_angle;
      span_x = (longint'(sb.regs.frac_length) * 6) / 5 + 2;
      span_y = (longint'(sb.regs.max_aperture) * 6) / 5 + 2;
      if (span_x > 64'hFFFF_FFFF) span_x = 64'hFFFF_FFFF;
      if (span_y > 64'hFFFF_FFFF) span_y = 64'hFFFF_FFFF;
      lx = longint'($urandom_range(0, 32'(span_x))) - span_x / 2;
      ly = longint'($urandom_range(0, 32'(span_y))) - span_y / 2;
      gx = longint'(sb.regs.center_x) + ((cs * lx - sn * ly) >>> 14);
      gy = longint'(sb.regs.center_y) + ((sn * lx + cs * ly) >>> 14);
      send_point(gx[31:0], gy[31:0]);
   endtask

   task automatic random_config(int phase);
      real         ang;
      logic [31:0] len, inv;
      ang = $urandom_range(0, 359) * 3.14159265358979 / 180.0;
      if ($urandom_range(0, 3) == 0) ang = $urandom_range(0, 3) * 1.5707963267949;
      len = ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(1, 32'h0100_0000);
      inv = (len == 0) ? 32'hFFFF_FFFF : 32'(((64'd1 << 40) / len) & 64'hFFFF_FFFF);
      if ($urandom_range(0, 3) == 0) inv = $urandom;
      csr_write(CSR_CENTER_X, ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1 << 24));
      csr_write(CSR_CENTER_Y, ($urandom_range(0, 3) == 0) ? $urandom : 32'(-$urandom_range(0, 1 << 24)));
      csr_write(CSR_COS_ANGLE, 32'($rtoi($cos(ang) * 16384.0)));
      csr_write(CSR_SIN_ANGLE, 32'($rtoi($sin(ang) * 16384.0)));
      csr_write(CSR_FRAC_LENGTH, len);
      csr_write(CSR_INV_LENGTH, inv);
      csr_write(CSR_MAX_APERTURE, ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 32'h0080_0000));
      csr_write(CSR_PROFILE_MODE, 32'(phase % 8));
      csr_write_en <= 1'b0;
   endtask

   initial begin
      sb = new();
      sb.reset_regs();
      reset        <= 1'b1;
      csr_write_en <= 1'b0;
      csr_index    <= '0;
      csr_wdata    <= '0;
      req_valid    <= 1'b0;
      req_point_x  <= '0;
      req_point_y  <= '0;
      rsp_stall    <= 1'b0;
      idling       = 1'b0;
      hold_off     = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: zero opening, only the centre line is inside
      send_point(32'd0, 32'd0);
      send_point(32'h0000_8000, 32'd0);
      send_point(32'h0000_8001, 32'd0);
      send_point(32'hFFFF_8000, 32'd0);
      send_point(32'd0, 32'd1);
      send_point(32'h7FFF_FFFF, 32'h8000_0000);
      send_point(32'h8000_0000, 32'h7FFF_FFFF);
      req_valid <= 1'b0;
      drain();

      // extreme registers
      csr_write(CSR_CENTER_X, 32'h7FFF_FFFF);
      csr_write(CSR_CENTER_Y, 32'h8000_0000);
      csr_write(CSR_COS_ANGLE, 32'hFFFF_C000);
      csr_write(CSR_SIN_ANGLE, 32'h0000_4000);
      csr_write(CSR_FRAC_LENGTH, 32'hFFFF_FFFF);
      csr_write(CSR_INV_LENGTH, 32'hFFFF_FFFF);
      csr_write(CSR_MAX_APERTURE, 32'hFFFF_FFFF);
      csr_write(CSR_PROFILE_MODE, 32'(MODE_ONESIDED));
      csr_write_en <= 1'b0;
      send_point(32'h7FFF_FFFF, 32'h8000_0000);
      send_point(32'h8000_0000, 32'h7FFF_FFFF);
      send_point(32'h0000_0000, 32'hFFFF_FFFF);
      send_point(32'h7FFF_0000, 32'h8000_0001);
      for (int i = 0; i < 6; i++) send_near();
      req_valid <= 1'b0;
      drain();

      // zero length with a wide quadratic opening
      csr_write(CSR_FRAC_LENGTH, 32'd0);
      csr_write(CSR_PROFILE_MODE, 32'(MODE_QUADRATIC));
      csr_write_en <= 1'b0;
      send_point(32'h7FFF_FFFF, 32'h8000_0000);
      send_point(32'h7FFF_FFFF, 32'h8000_0001);
      send_point(32'h7FFF_FFFE, 32'h8000_0000);
      req_valid <= 1'b0;
      drain();

      for (int phase = 0; phase < 16; phase++) begin
         random_config(phase);
         idling   = (phase % 4) != 1;
         hold_off = (phase == 5 || phase == 11);
         for (int i = 0; i < 82; i++) begin
            if ($urandom_range(0, 9) < 7) send_near();
            else send_point($urandom, $urandom);
         end
         req_valid <= 1'b0;
         drain();
      end

      if (sb.mismatches == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

   // result side
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         gap = idling ? $urandom_range(0, 16) : 0;
         if (hold_off) begin
            hold_off = 1'b0;
            gap      = 400;
         end
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         forever begin
            @(posedge clock);
            if (rsp_valid) break;
         end
         sb.check_beat(rsp_inside_res, rsp_aperture, rsp_permeability);
      end
   end

endmodule

FILE: files.f
rtl/core/fpa_pkg.sv
rtl/core/fpa_front.sv
rtl/core/fpa_queue.sv
rtl/core/fpa_sqrt.sv
rtl/core/fpa_back.sv
rtl/core/fracture_point_aperture_top.sv
tb/fracture_point_aperture_top_tb.sv
